FILE: design/fdf_pkg.sv
// fdf_pkg: widths, alarm codes and command codes for the flood duplicate filter.
// No dependencies; imported by fdf_history and the top level flood_duplicate_filter.
`timescale 1ns / 1ps
`default_nettype none
package fdf_pkg;

	localparam int ID_CHARS   = 4;
	localparam int CODE_CHARS = 3;
	localparam int ID_W       = 14;   // up to 9999
	localparam int CODE_W     = 10;   // up to 999

	localparam logic [CODE_W-1:0] CODE_ON  = CODE_W'(112);
	localparam logic [CODE_W-1:0] CODE_OFF = CODE_W'(110);

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_ON   = 2'd1;
	localparam logic [1:0] CMD_OFF  = 2'd2;

	// lookup and update request into the history ring
	typedef struct packed {
		logic            upd;   // message leaves stage 1 this cycle
		logic [ID_W-1:0] id;
	} hist_req_t;

endpackage
`default_nettype wire

FILE: design/fdf_ascii_dec.sv
// fdf_ascii_dec: ASCII decimal to binary, stops at the first non-digit.
// Depends on nothing outside itself.
`timescale 1ns / 1ps
`default_nettype none
module fdf_ascii_dec #(
	parameter int NCHARS = 4,
	parameter int VAL_W  = 14
) (
	input  wire logic [8*NCHARS-1:0] chars,   // first character in top byte
	output logic      [VAL_W-1:0]    value
);

	always_comb begin
		logic [VAL_W-1:0] acc;
		logic             run;
		logic [7:0]       ch;
		acc = '0;
		run = 1'b1;
		for (int k = 0; k < NCHARS; k++) begin
			ch = chars[8*(NCHARS-1-k) +: 8];
			if (run && (ch inside {[8'h30:8'h39]})) begin
				acc = VAL_W'(acc * 10) + VAL_W'(ch - 8'h30);
			end else begin
				run = 1'b0;
			end
		end
		value = acc;
	end

endmodule
`default_nettype wire

FILE: design/fdf_history.sv
// fdf_history: ring of recently seen IDs with valid bits, parallel match and head pointer.
// Depends on fdf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fdf_history
	import fdf_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire hist_req_t req,
	output logic           hit
);

	localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(HISTORY_DEPTH - 1);

	logic [ID_W-1:0]          id_q [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] valid_q;
	logic [HEAD_W-1:0]        head_q;
	logic [HISTORY_DEPTH-1:0] match;

	always_comb begin
		for (int k = 0; k < HISTORY_DEPTH; k++) begin
			match[k] = valid_q[k] && (id_q[k] == req.id);
		end
	end

	assign hit = |match;

	// control: valid bits and head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q  <= '0;
		end else if (req.upd && !hit) begin
			valid_q[head_q] <= 1'b1;
			head_q          <= (head_q == HEAD_LAST) ? '0 : head_q + HEAD_W'(1);
		end
	end

	// stored IDs, no reset: read only behind a valid bit
	always_ff @(posedge clk) begin
		if (req.upd && !hit) begin
			id_q[head_q] <= req.id;
		end
	end

endmodule
`default_nettype wire

FILE: design/flood_duplicate_filter.sv
// flood_duplicate_filter: top level, stream ports, stage-1 register and result register.
// Depends on fdf_pkg, fdf_ascii_dec and fdf_history.
`timescale 1ns / 1ps
`default_nettype none
// Duplicate suppression for flooded alarm messages. Each input transfer carries
// a four-character ASCII message ID and a three-character ASCII alarm code; both
// are read as decimal, stopping at the first non-digit (a leading non-digit
// gives 0). The ID is matched against the last HISTORY_DEPTH distinct IDs. A hit
// yields is_duplicate and leaves everything unchanged; a miss stores the ID,
// sets rebroadcast and applies the alarm code (112 LED on, 110 LED off). Valid
// bits are cleared at reset, so ID 0 is not a false duplicate. Throughput is one
// transfer per cycle while m_tready stays high. There are two register stages
// (stage-1 register, then the match/update cycle into the result register): an
// input transfer is captured in the stage-1 register and then moves into the
// result register, which drives m_tvalid.
// The history is updated on the same edge the result is registered, so the next
// message already sees it. When the result is not taken, one more transfer is
// still accepted into an empty stage 1; after that s_tready stays low until
// m_tready returns, and it follows m_tready in the same cycle.
module flood_duplicate_filter
	import fdf_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10   // 2..64 entries
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,    // [31:0] id_chars, [55:32] alarm_chars
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata     // [0] is_duplicate, [1] rebroadcast,
	                                     // [3:2] alarm_command, [4] alarm_led, [7:5] zero
);

	logic [8*ID_CHARS-1:0]   id_chars_s1;
	logic [8*CODE_CHARS-1:0] alarm_chars_s1;
	logic                    valid_s1;

	logic                    out_valid_q;
	logic                    dup_q;
	logic [1:0]              cmd_q;
	logic                    led_q;      // LED state, also the alarm_led field

	logic [ID_W-1:0]   id_val;
	logic [CODE_W-1:0] code_val;
	logic              adv;              // result register can load
	logic              fire_s1;          // stage-1 message moves to result
	logic              hit;
	hist_req_t         hreq;
	logic [1:0]        cmd_next;
	logic              led_next;

	assign adv      = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// stage 1: capture the raw characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			id_chars_s1    <= s_tdata[31:0];
			alarm_chars_s1 <= s_tdata[55:32];
		end
	end

	fdf_ascii_dec #(.NCHARS(ID_CHARS), .VAL_W(ID_W)) u_id_dec (
		.chars (id_chars_s1),
		.value (id_val)
	);

	fdf_ascii_dec #(.NCHARS(CODE_CHARS), .VAL_W(CODE_W)) u_code_dec (
		.chars (alarm_chars_s1),
		.value (code_val)
	);

	assign hreq.upd = fire_s1;
	assign hreq.id  = id_val;

	fdf_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.hit    (hit)
	);

	// alarm command applies only to new messages
	always_comb begin
		cmd_next = CMD_NONE;
		led_next = led_q;
		if (!hit) begin
			if (code_val == CODE_ON) begin
				cmd_next = CMD_ON;
				led_next = 1'b1;
			end else if (code_val == CODE_OFF) begin
				cmd_next = CMD_OFF;
				led_next = 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			led_q       <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				led_q <= led_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			dup_q <= hit;
			cmd_q <= cmd_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, led_q, cmd_q, !dup_q, dup_q};

endmodule
`default_nettype wire

FILE: sim/flood_duplicate_filter_tb.sv
// flood_duplicate_filter_tb: self-checking bench for the alarm duplicate filter.
// Depends on fdf_pkg and flood_duplicate_filter; directed cases, then random traffic with stalls.
`timescale 1ns / 1ps
module flood_duplicate_filter_tb;
	import fdf_pkg::*;

	localparam int DEPTH     = 10;
	localparam int LIMIT     = 500000;
	localparam int N_RANDOM  = 1500;
	localparam logic [23:0] TXT_ON  = "112";
	localparam logic [23:0] TXT_OFF = "110";

	typedef struct {
		logic       dup;
		logic       fwd;
		logic [1:0] cmd;
		logic       led;
	} verdict_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	flood_duplicate_filter #(.HISTORY_DEPTH(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// own copy of the filter state
	logic [ID_W-1:0] seen_id    [DEPTH];
	logic            seen_valid [DEPTH] = '{default: 1'b0};
	int unsigned     write_slot = 0;
	logic            led_now    = 1'b0;

	verdict_t verdict_q[$];

	int errors     = 0;
	int sent       = 0;
	int received   = 0;
	int dup_seen   = 0;
	int on_seen    = 0;
	int off_seen   = 0;
	int cycles     = 0;
	int hold_len   = 0;     // long receiver hold requested by the pressure test
	bit send_idle  = 1'b1;
	bit recv_idle  = 1'b1;

	// atoi over up to four characters, most significant byte first
	function automatic int unsigned ascii_decimal(logic [31:0] chars, int count);
		int unsigned value;
		logic [7:0]  ch;
		bit          stop;
		int          k;
		value = 0;
		stop  = 1'b0;
		for (k = count - 1; k >= 0; k--) begin
			ch = chars[8*k +: 8];
			if (ch < 8'h30 || ch > 8'h39)
				stop = 1'b1;
			if (!stop)
				value = value * 10 + (ch - 8'h30);
		end
		return value;
	endfunction

	// four decimal digits with leading zeros; low three bytes give a three-digit code
	function automatic logic [31:0] digit_text(int n);
		logic [31:0] t;
		int          k;
		for (k = 0; k < 4; k++) begin
			t[8*k +: 8] = 8'h30 + 8'(n % 10);
			n = n / 10;
		end
		return t;
	endfunction

	// lookup against the ring, insert on a miss, apply the alarm code
	function automatic verdict_t filter_message(logic [31:0] id_chars, logic [23:0] alarm_chars);
		verdict_t        v;
		logic [ID_W-1:0] id;
		logic [CODE_W-1:0] code;
		logic            hit;
		int              k;
		id   = ID_W'(ascii_decimal(id_chars, ID_CHARS));
		code = CODE_W'(ascii_decimal({8'h00, alarm_chars}, CODE_CHARS));
		hit  = 1'b0;
		for (k = 0; k < DEPTH; k++)
			if (seen_valid[k] && seen_id[k] == id)
				hit = 1'b1;
		v.cmd = CMD_NONE;
		if (!hit) begin
			seen_id[write_slot]    = id;
			seen_valid[write_slot] = 1'b1;
			write_slot = (write_slot + 1) % DEPTH;
			if (code == CODE_ON) begin
				led_now = 1'b1;
				v.cmd   = CMD_ON;
			end else if (code == CODE_OFF) begin
				led_now = 1'b0;
				v.cmd   = CMD_OFF;
			end
		end
		v.dup = hit;
		v.fwd = !hit;
		v.led = led_now;
		return v;
	endfunction

	task automatic note_mismatch(string what, int got, int want);
		$display("mismatch: %s on result %0d, got %0d, expected %0d",
			what, received, got, want);
		errors++;
	endtask

	// one input transfer; called at a rising edge, returns at the accepting edge
	task automatic send_msg(logic [31:0] id_chars, logic [23:0] alarm_chars);
		int gap;
		gap = send_idle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {alarm_chars, id_chars};
		do @(posedge clk); while (!s_tready);
		verdict_q.push_back(filter_message(id_chars, alarm_chars));
		sent++;
	endtask

	// result side: random stalls, the occasional long hold, field-by-field check
	initial begin
		int       stall;
		verdict_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 14) : 0;
			if (hold_len != 0) begin
				stall    = hold_len;
				hold_len = 0;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			received++;
			if (verdict_q.size() == 0) begin
				note_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[0] !== want.dup)
					note_mismatch("is_duplicate", m_tdata[0], want.dup);
				if (m_tdata[1] !== want.fwd)
					note_mismatch("rebroadcast", m_tdata[1], want.fwd);
				if (m_tdata[3:2] !== want.cmd)
					note_mismatch("alarm_command", m_tdata[3:2], want.cmd);
				if (m_tdata[4] !== want.led)
					note_mismatch("alarm_led", m_tdata[4], want.led);
				dup_seen += want.dup;
				on_seen  += (want.cmd == CMD_ON);
				off_seen += (want.cmd == CMD_OFF);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout with %0d results outstanding", verdict_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ID zero must not look like a duplicate straight after reset
	task automatic test_zero_id();
		send_msg("0000", TXT_ON);
		send_msg("0000", TXT_OFF);      // duplicate: LED stays on
		send_msg("ABCD", TXT_OFF);      // non-numeric -> 0, duplicate
		send_msg("    ", "000");
	endtask

	// digit boundaries, early stop, extreme bit patterns, code variants
	task automatic test_conversion();
		send_msg("9999", TXT_OFF);
		send_msg("12a4", TXT_ON);       // reads as 12
		send_msg("0012", TXT_OFF);      // 12 again
		send_msg("1/34", "11x");        // '/' just below '0'
		send_msg("2:34", " 12");        // ':' just above '9'
		send_msg(32'hFFFF_FFFF, 24'hFF_FFFF);
		send_msg(32'h0000_0000, 24'h00_0000);
		send_msg("0777", TXT_ON);
	endtask

	// eleven fresh IDs push the first one out of the ring
	task automatic test_ring_wrap();
		int k;
		for (k = 0; k < DEPTH + 1; k++)
			send_msg(digit_text(5000 + k), 24'(digit_text($urandom_range(105, 115))));
		send_msg(digit_text(5000), TXT_OFF);
		send_msg(digit_text(5000 + DEPTH), TXT_ON);
	endtask

	// receiver holds off while the sender keeps offering: input must stall
	task automatic test_backpressure();
		int k;
		send_idle = 1'b0;
		hold_len  = 300;
		for (k = 0; k < 24; k++)
			send_msg(digit_text($urandom_range(0, 30)), $urandom_range(0, 1) ? TXT_ON : TXT_OFF);
		send_idle = 1'b1;
	endtask

	// mostly well-formed messages over a small ID pool, some raw noise
	task automatic test_random();
		logic [31:0] id_chars;
		logic [23:0] alarm_chars;
		int          k;
		int          pick;
		for (k = 0; k < N_RANDOM; k++) begin
			if (k % 100 == 0) begin
				// chunks alternate idling patterns, some with none on either side
				send_idle = $urandom_range(0, 2) != 0;
				recv_idle = $urandom_range(0, 2) != 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				id_chars = digit_text($urandom_range(0, 24) * 397 % 10000);
				if ($urandom_range(0, 9) == 0)
					id_chars[7:0] = 8'h20;   // truncated ID
				case ($urandom_range(0, 4))
					0, 1:    alarm_chars = TXT_ON;
					2, 3:    alarm_chars = TXT_OFF;
					default: alarm_chars = 24'(digit_text($urandom_range(0, 999)));
				endcase
			end else begin
				id_chars    = $urandom;
				alarm_chars = 24'($urandom);
			end
			send_msg(id_chars, alarm_chars);
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_id();
		test_conversion();
		test_ring_wrap();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d messages sent, %0d results checked: %0d duplicates, %0d LED on, %0d LED off",
			sent, received, dup_seen, on_seen, off_seen);
		$display("covered ID zero, early-stop conversion, ring wrap and a 300-cycle output hold");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
design/fdf_pkg.sv
design/fdf_ascii_dec.sv
design/fdf_history.sv
design/flood_duplicate_filter.sv
sim/flood_duplicate_filter_tb.sv
